/* rtl/plec_pkg.sv */
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps

package plec_pkg;

   localparam int OP_W   = 3;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int ST_W   = 2;
   localparam int LEN_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_HEAD = 3'd0,
      OP_TAIL = 3'd1,
      OP_POS  = 3'd2,
      OP_DEL  = 3'd3,
      OP_READ = 3'd4
   } plec_op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } plec_status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } plec_state_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic ins;    // open a gap at the chosen index
      logic del;    // close the gap at the chosen index
      logic load;   // copy cell contents into the read-out chain
      logic shift;  // move the read-out chain one cell toward the head
   } plec_ctl_type;

endpackage

/* rtl/plec_if.sv */
// Request and response channel interfaces of the positional list engine.
`timescale 1ns / 1ps

interface plec_req_if;
   logic                                valid;
   logic                                ready;
   logic [plec_pkg::OP_W-1:0]           op;
   logic [plec_pkg::POS_W-1:0]          position;
   logic signed [plec_pkg::DATA_W-1:0]  item_value;

   modport source (output valid, output op, output position, output item_value,
                   input ready);
   modport sink   (input valid, input op, input position, input item_value,
                   output ready);
endinterface

interface plec_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [plec_pkg::ST_W-1:0]           status;
   logic signed [plec_pkg::DATA_W-1:0]  read_value;
   logic [plec_pkg::LEN_W-1:0]          list_length;

   modport source (output valid, output status, output read_value, output list_length,
                   input ready);
   modport sink   (input valid, input status, input read_value, input list_length,
                   output ready);
endinterface

/* rtl/plec_cell.sv */
// One list cell: holds an element and one stage of the read-out chain.
`timescale 1ns / 1ps

module plec_cell #(
   parameter int IDX_W = 8,
   parameter int INDEX = 0
) (
   input  logic                               clock,
   input  plec_pkg::plec_ctl_type             ctl,
   input  logic [IDX_W-1:0]                   gap,
   input  logic signed [plec_pkg::DATA_W-1:0] ins_value,
   input  logic signed [plec_pkg::DATA_W-1:0] left,
   input  logic signed [plec_pkg::DATA_W-1:0] right,
   input  logic signed [plec_pkg::DATA_W-1:0] bus_right,
   output logic signed [plec_pkg::DATA_W-1:0] cell_q,
   output logic signed [plec_pkg::DATA_W-1:0] bus_q
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [plec_pkg::DATA_W-1:0] cell_ff, cell_in;
   logic signed [plec_pkg::DATA_W-1:0] bus_ff, bus_in;

   // element: shift away from the head on insert, toward it on delete
   always_comb begin
      cell_in = cell_ff;
      if (ctl.ins) begin
         if (MY_IDX > gap) begin
            cell_in = left;
         end else if (MY_IDX == gap) begin
            cell_in = ins_value;
         end
      end else if (ctl.del && (MY_IDX >= gap)) begin
         cell_in = right;
      end
   end

   // read-out chain: snapshot of the list, drained toward cell 0
   always_comb begin
      bus_in = bus_ff;
      if (ctl.load) begin
         bus_in = cell_ff;
      end else if (ctl.shift) begin
         bus_in = bus_right;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      bus_ff  <= bus_in;
   end

   assign cell_q = cell_ff;
   assign bus_q  = bus_ff;

endmodule

/* rtl/positional_list_engine_core.sv */
// Inserts and refused requests give their response in the cycle after acceptance.
// Delete and read at position p give their response once the element reaches cell 0,
// carried by the read-out chain moving the element one cell per cycle toward the head.
// Throughput: one request at a time; a new request is taken once the response is out.
// Reset (synchronous) empties the list and drops any pending response; cell contents
// are left as they are and are never read before being written.
`timescale 1ns / 1ps

module positional_list_engine_core #(
   parameter int CAPACITY = 64
) (
   input logic          clock,
   input logic          reset,
   plec_req_if.sink     req_ch,
   plec_rsp_if.source   rsp_ch
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((CW > plec_pkg::POS_W) ? CW : plec_pkg::POS_W) + 1;

   // control state
   plec_pkg::plec_state_type          state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [plec_pkg::POS_W-1:0]        scan_ff, scan_in;
   logic [plec_pkg::LEN_W-1:0]        pend_len_ff, pend_len_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // response payload
   plec_pkg::plec_status_type          rsp_status_ff, rsp_status_in;
   logic signed [plec_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [plec_pkg::LEN_W-1:0]         rsp_len_ff, rsp_len_in;

   // chain wiring
   logic signed [plec_pkg::DATA_W-1:0] cell_q    [CAPACITY];
   logic signed [plec_pkg::DATA_W-1:0] bus_q     [CAPACITY];
   logic signed [plec_pkg::DATA_W-1:0] left_v    [CAPACITY];
   logic signed [plec_pkg::DATA_W-1:0] right_v   [CAPACITY];
   logic signed [plec_pkg::DATA_W-1:0] bus_r_v   [CAPACITY];
   plec_pkg::plec_ctl_type             ctl;
   logic [EW-1:0]                      gap;

   logic                               req_ready;
   logic                               full;
   logic                               immediate;
   logic [EW-1:0]                      pos_e;
   logic [EW-1:0]                      cnt_e;
   logic [EW-1:0]                      idx_e;
   plec_pkg::plec_op_type              op_v;
   plec_pkg::plec_status_type          status_v;

   assign pos_e = EW'(req_ch.position);
   assign cnt_e = EW'(count_ff);
   assign idx_e = pos_e - EW'(1);
   assign full  = (count_ff == CW'(CAPACITY));
   assign op_v  = plec_pkg::plec_op_type'(req_ch.op);

   // next state, chain commands and response loading
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pend_len_in   = pend_len_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_len_in    = rsp_len_ff;
      ctl           = '0;
      gap           = '0;
      immediate     = 1'b1;
      status_v      = plec_pkg::ST_OK;
      req_ready     = (state_ff == plec_pkg::S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         plec_pkg::S_IDLE: begin
            if (req_ch.valid && req_ready) begin
               case (op_v)
                  plec_pkg::OP_HEAD: begin
                     if (full) begin
                        status_v = plec_pkg::ST_FULL;
                     end else begin
                        ctl.ins  = 1'b1;
                        gap      = '0;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  plec_pkg::OP_TAIL: begin
                     if (full) begin
                        status_v = plec_pkg::ST_FULL;
                     end else begin
                        ctl.ins  = 1'b1;
                        gap      = cnt_e;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  plec_pkg::OP_POS: begin
                     if (full) begin
                        status_v = plec_pkg::ST_FULL;
                     end else if ((pos_e == '0) || (pos_e > cnt_e + EW'(1))) begin
                        status_v = plec_pkg::ST_BADPOS;
                     end else begin
                        ctl.ins  = 1'b1;
                        gap      = idx_e;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  plec_pkg::OP_DEL: begin
                     if ((pos_e == '0) || (pos_e > cnt_e)) begin
                        status_v = plec_pkg::ST_BADPOS;
                     end else begin
                        ctl.del   = 1'b1;
                        ctl.load  = 1'b1;
                        gap       = idx_e;
                        count_in  = count_ff - CW'(1);
                        immediate = 1'b0;
                     end
                  end
                  plec_pkg::OP_READ: begin
                     if ((pos_e == '0) || (pos_e > cnt_e)) begin
                        status_v = plec_pkg::ST_BADPOS;
                     end else begin
                        ctl.load  = 1'b1;
                        immediate = 1'b0;
                     end
                  end
                  default: begin
                     status_v = plec_pkg::ST_BADPOS;
                  end
               endcase

               if (immediate) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = status_v;
                  rsp_value_in  = '0;
                  rsp_len_in    = plec_pkg::LEN_W'(count_in);
               end else begin
                  state_in    = plec_pkg::S_SCAN;
                  scan_in     = plec_pkg::POS_W'(idx_e);
                  pend_len_in = plec_pkg::LEN_W'(count_in);
               end
            end
         end
         plec_pkg::S_SCAN: begin
            // element reaches cell 0 after position-1 shifts
            if (scan_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = plec_pkg::ST_OK;
               rsp_value_in  = bus_q[0];
               rsp_len_in    = pend_len_ff;
               state_in      = plec_pkg::S_IDLE;
            end else begin
               ctl.shift = 1'b1;
               scan_in   = scan_ff - plec_pkg::POS_W'(1);
            end
         end
         default: begin
            state_in = plec_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plec_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      pend_len_ff   <= pend_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_len_ff    <= rsp_len_in;
   end

   // row of cells, each linked to its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_v[i] = '0;
      end else begin : g_mid_l
         assign left_v[i] = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_v[i] = cell_q[i];
         assign bus_r_v[i] = '0;
      end else begin : g_mid_r
         assign right_v[i] = cell_q[i+1];
         assign bus_r_v[i] = bus_q[i+1];
      end

      plec_cell #(
         .IDX_W (EW),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .gap       (gap),
         .ins_value (req_ch.item_value),
         .left      (left_v[i]),
         .right     (right_v[i]),
         .bus_right (bus_r_v[i]),
         .cell_q    (cell_q[i]),
         .bus_q     (bus_q[i])
      );
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.read_value  = rsp_value_ff;
   assign rsp_ch.list_length = rsp_len_ff;

endmodule
